/* design/largest_empty_square_scan_core_defines.svh */
// Shared assertion macros for the scan core checkers.
`ifndef LARGEST_EMPTY_SQUARE_SCAN_CORE_DEFINES_SVH
`define LARGEST_EMPTY_SQUARE_SCAN_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LESQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lesq assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define LESQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lesq assertion failed");

`endif

/* design/lesq_pkg.sv */
package lesq_pkg;

  localparam int MAX_COLS = 4096;
  localparam int MAX_ROWS = 4096;
  localparam int ADDR_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam int CHAR_W = 8;
  localparam int POS_W  = 12;
  localparam int SIZE_W = 13;
  localparam int STAT_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_FIRST = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_LATER = 2'd2;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_WALL_CHAR  = 1'b0;
  localparam cfg_index_t REG_EMPTY_CHAR = 1'b1;

  localparam logic [CHAR_W-1:0] WALL_CHAR_RST  = 8'd111;
  localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST = 8'd46;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [SIZE_W-1:0] size_t;

  typedef struct packed {
    char_t cell_req;
    pos_t  col;
    pos_t  row;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    size_t             best_size;
    pos_t              best_row;
    pos_t              best_col;
  } out_word_t;

endpackage

/* design/lesq_ram.sv */
module lesq_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/largest_empty_square_scan_core.sv */
// Largest empty square scanner.
// Map cells enter on the in_ channel in row-major order, one word per cell,
// carrying the character, its column and its row. For every accepted word one
// result word leaves on the out_ channel with a status and the largest free
// square found so far, given by its side and its bottom-right corner.
// A valid cell at row 0, column 0 starts a new map and clears the best square.
// The block takes one word per cycle while the receiver does not stall. An
// accepted word is registered in the scoring stage together with the read of
// the line memory that holds the square sizes of the latest row, and its result
// is registered in the output word when the scoring stage advances.
// While the receiver stalls, the result word holds and one more word may sit
// in the scoring stage; beyond that in_stall rises in the same cycle.
// The cfg_ channel writes the wall and empty character codes; it is always
// ready; it is to be written only while no words are in flight, which the block itself does not enforce.
// Reset empties the pipeline, clears the best square and restores the default
// character codes.
// The line memory needs no clearing pass: each entry is written in row 0
// before its value is used, provided the cells of row 0 are valid.
module largest_empty_square_scan_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lesq_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lesq_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  lesq_pkg::cfg_index_t cfg_index,
  input  lesq_pkg::char_t      cfg_data
);
  import lesq_pkg::*;

  char_t     wall_r, wall_nxt, empty_r, empty_nxt;
  logic      s1_v_r, s1_v_nxt;
  in_word_t  s1_word_r;
  logic      fwd_up_r, fwd_left_r;
  size_t     fwd_data_r;
  size_t     diag_r, diag_nxt, best_r, best_nxt;
  pos_t      crow_r, crow_nxt, ccol_r, ccol_nxt;
  logic      out_v_r, out_v_nxt;
  out_word_t out_word_r, out_word_nxt;

  logic              accept, advance, out_free;
  logic [ADDR_W-1:0] rd_up_addr, rd_left_addr, wr_addr;
  logic              wr_en;
  size_t             ram_up, ram_left, up, left, min_ul, min_all, size;
  size_t             best_base;
  pos_t              crow_base, ccol_base;
  logic              in_range, is_wall, is_free, ok, clear;
  logic [STAT_W-1:0] status;

  assign out_free = !out_v_r || !out_stall;
  assign advance  = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign rd_up_addr   = ADDR_W'(in_data.col);
  assign rd_left_addr = ADDR_W'(in_data.col - POS_W'(1));
  assign wr_addr      = ADDR_W'(s1_word_r.col);

  lesq_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_COLS)) u_ram_up (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(size),
    .re   (accept),
    .raddr(rd_up_addr),
    .rdata(ram_up)
  );

  lesq_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_COLS)) u_ram_left (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(size),
    .re   (accept),
    .raddr(rd_left_addr),
    .rdata(ram_left)
  );

  always_comb begin
    in_range = (32'(s1_word_r.col) < MAX_COLS) && (32'(s1_word_r.row) < MAX_ROWS);
    is_wall  = (s1_word_r.cell_req == wall_r);
    is_free  = !is_wall && (s1_word_r.cell_req == empty_r);
    ok       = in_range && (is_wall || is_free);
    clear    = ok && (s1_word_r.row == '0) && (s1_word_r.col == '0);
    wr_en    = advance && ok;

    if (in_range && !ok) begin
      status = (s1_word_r.row == '0) ? ST_BAD_FIRST : ST_BAD_LATER;
    end else begin
      status = ST_OK;
    end

    up      = fwd_up_r ? fwd_data_r : ram_up;
    left    = fwd_left_r ? fwd_data_r : ram_left;
    min_ul  = (left < up) ? left : up;
    min_all = (diag_r < min_ul) ? diag_r : min_ul;

    if (!is_free) begin
      size = '0;
    end else if ((s1_word_r.row == '0) || (s1_word_r.col == '0)) begin
      size = SIZE_W'(1);
    end else if (min_all == SIZE_SAT) begin
      size = SIZE_SAT;
    end else begin
      size = min_all + SIZE_W'(1);
    end

    best_base = clear ? '0 : best_r;
    crow_base = clear ? '0 : crow_r;
    ccol_base = clear ? '0 : ccol_r;
  end

  always_comb begin
    wall_nxt  = wall_r;
    empty_nxt = empty_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WALL_CHAR:  wall_nxt = cfg_data;
        REG_EMPTY_CHAR: empty_nxt = cfg_data;
        default: ;
      endcase
    end

    s1_v_nxt = accept ? 1'b1 : (advance ? 1'b0 : s1_v_r);

    diag_nxt = diag_r;
    best_nxt = best_r;
    crow_nxt = crow_r;
    ccol_nxt = ccol_r;
    if (ok) begin
      best_nxt = best_base;
      crow_nxt = crow_base;
      ccol_nxt = ccol_base;
      if (size > best_base) begin
        best_nxt = size;
        crow_nxt = s1_word_r.row;
        ccol_nxt = s1_word_r.col;
      end
    end

    out_word_nxt.status    = status;
    out_word_nxt.best_size = best_nxt;
    out_word_nxt.best_row  = crow_nxt;
    out_word_nxt.best_col  = ccol_nxt;

    out_v_nxt = advance ? 1'b1 : (out_free ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_r  <= WALL_CHAR_RST;
      empty_r <= EMPTY_CHAR_RST;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      diag_r  <= '0;
      best_r  <= '0;
      crow_r  <= '0;
      ccol_r  <= '0;
    end else begin
      wall_r  <= wall_nxt;
      empty_r <= empty_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (wr_en) begin
        diag_r <= (s1_word_r.row == '0) ? '0 : up;
        best_r <= best_nxt;
        crow_r <= crow_nxt;
        ccol_r <= ccol_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r  <= in_data;
      fwd_up_r   <= wr_en && (wr_addr == rd_up_addr);
      fwd_left_r <= wr_en && (wr_addr == rd_left_addr);
      fwd_data_r <= size;
    end
    if (advance) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_word_r;

endmodule

/* design/lesq_checker.sv */
`include "largest_empty_square_scan_core_defines.svh"

module lesq_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input lesq_pkg::in_word_t   in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input lesq_pkg::out_word_t  out_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input lesq_pkg::cfg_index_t cfg_index,
  input lesq_pkg::char_t      cfg_data
);
  import lesq_pkg::*;

  logic in_acc;
  logic cfg_seen;

  assign in_acc   = in_valid && !in_stall;
  assign cfg_seen = cfg_valid && cfg_ready && ((cfg_index == REG_WALL_CHAR) ||
                    (cfg_index == REG_EMPTY_CHAR)) && (cfg_data == cfg_data);

  `LESQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `LESQ_ASSERT_NEXT(a_result_follows, in_acc, ##1 out_valid)
  `LESQ_ASSERT_NOW(a_status_code, out_valid, (out_data.status == ST_OK) ||
                   (out_data.status == ST_BAD_FIRST) || (out_data.status == ST_BAD_LATER))
  `LESQ_ASSERT_NOW(a_empty_best_corner, out_valid && (out_data.best_size == '0),
                   (out_data.best_row == '0) && (out_data.best_col == '0))
  `LESQ_ASSERT_NOW(a_cfg_ready, cfg_seen || in_data.row == in_data.row, cfg_ready)

endmodule

bind largest_empty_square_scan_core lesq_checker u_lesq_checker (.*);
